FILE: rtl/vf_frequency_ramp_generator_top_defines.svh
// Assertion macros for the V/f frequency ramp generator.
// Used by vf_frequency_ramp_generator_top; expects signals named clock and reset.
`ifndef VF_FREQUENCY_RAMP_GENERATOR_TOP_DEFINES_SVH
`define VF_FREQUENCY_RAMP_GENERATOR_TOP_DEFINES_SVH
`ifndef SYNTH
`define VFRG_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vfrg assertion failed");
`define VFRG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vfrg assertion failed");
`else
`define VFRG_ASSERT_IMPL(label, ante, cons)
`define VFRG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/vfrg_pkg.sv
`timescale 1ns / 1ps
// Package of the V/f frequency ramp generator: register indexes, reset values,
// fixed-point constants and the stage payload type. No dependencies.
package vfrg_pkg;

   typedef logic [2:0] csr_index_type;

   localparam csr_index_type CSR_RAMP_STEP       = 3'd0;
   localparam csr_index_type CSR_RAMP_PERIOD     = 3'd1;
   localparam csr_index_type CSR_MAX_TARGET_HZ   = 3'd2;
   localparam csr_index_type CSR_ANGLE_GAIN      = 3'd3;
   localparam csr_index_type CSR_LED_LEVEL_ONE   = 3'd4;
   localparam csr_index_type CSR_LED_LEVEL_TWO   = 3'd5;
   localparam csr_index_type CSR_LED_LEVEL_THREE = 3'd6;

   localparam logic [5:0]         RST_RAMP_STEP       = 6'd1;
   localparam logic [9:0]         RST_RAMP_PERIOD     = 10'd100;
   localparam logic [7:0]         RST_MAX_TARGET_HZ   = 8'd50;
   localparam logic [9:0]         RST_ANGLE_GAIN      = 10'd256;
   localparam logic signed [15:0] RST_LED_LEVEL_ONE   = 16'sd10;
   localparam logic signed [15:0] RST_LED_LEVEL_TWO   = 16'sd25;
   localparam logic signed [15:0] RST_LED_LEVEL_THREE = 16'sd40;

   // Target in hertz is (adc + 42) / 82, done as a multiply by 2^24 / 82 rounded up.
   localparam logic [6:0]  ADC_ROUND    = 7'd42;
   localparam int          DIV82_RECIP_W = 18;
   localparam logic [17:0] DIV82_RECIP  = 18'd204601;
   localparam int          DIV82_SHIFT  = 24;

   localparam logic [11:0] FREQ_MAX      = 12'd2500;
   // Amplitude is frequency in tenths of a hertz * 8192 / 125, full scale from 50 Hz upwards.
   localparam logic [11:0] AMP_SAT_FREQ  = 12'd500;
   localparam logic [15:0] AMP_FULL      = 16'd32768;
   localparam logic [26:0] AMP_RECIP     = 27'd68719477;
   localparam int          AMP_SHIFT     = 20;

   localparam logic [19:0] ANGLE_WRAP    = 20'd400000;

   typedef struct packed {
      logic [11:0] freq;
      logic        running;
      logic [2:0]  leds;
   } ramp_result_type;

endpackage

FILE: rtl/vf_frequency_ramp_generator_top.sv
`timescale 1ns / 1ps
// Top level of the V/f frequency ramp generator: target selection, ramp,
// amplitude, phase angle and speed bar. Depends on vfrg_pkg and the defines header.
//
// One request item is one 100 us control tick: ADC sample, start and stop buttons
// and measured speed. Each request gives exactly one response item with frequency,
// V/f amplitude, phase angle, run flag and LED count, in request order.
// Both channels use valid and ready. The request is captured in an input register,
// the run flag, target and ramp state are updated in the second stage, and the
// amplitude and phase angle are formed into the output register in the third.
// The response is registered in stage two and then in the output register. One item
// can be accepted every cycle while the receiver does not stall; the rate is set by
// the state update in stage two. When the receiver stalls, the stages fill and
// req_ready falls once all three hold items; nothing is dropped. The configuration
// port is always ready; the user must write it only while the block is idle, which
// the block itself does not enforce. Synchronous reset clears the pipeline, the run
// flag, target, tick counter, frequency and angle, and loads the register defaults.
`include "vf_frequency_ramp_generator_top_defines.svh"
module vf_frequency_ramp_generator_top #(
   parameter int ADC_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [ADC_BITS-1:0]   req_adc_target,
   input  logic                  req_start_button,
   input  logic                  req_stop_button,
   input  logic signed [15:0]    req_speed_el,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [11:0]           rsp_freq_tenths,
   output logic [15:0]           rsp_amplitude,
   output logic [18:0]           rsp_phase_angle,
   output logic                  rsp_running,
   output logic [2:0]            rsp_led_count,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  vfrg_pkg::csr_index_type csr_index,
   input  logic [15:0]           csr_data
);

   localparam int SUM_W  = ADC_BITS + 1;
   localparam int Q_W    = SUM_W - 6;
   localparam int PROD_W = SUM_W + vfrg_pkg::DIV82_RECIP_W;
   localparam int CMP_W  = (Q_W > 8) ? Q_W : 8;

   logic [5:0]         step_ff;
   logic [9:0]         period_ff;
   logic [7:0]         max_hz_ff;
   logic [9:0]         gain_ff;
   logic signed [15:0] lvl1_ff, lvl2_ff, lvl3_ff;

   logic               a_valid_ff;
   logic [Q_W-1:0]     a_quot_ff;
   logic               a_start_ff, a_stop_ff;
   logic signed [15:0] a_speed_ff;

   logic                      b_valid_ff;
   vfrg_pkg::ramp_result_type b_ff, b_in;

   logic        rsp_valid_ff;
   logic [11:0] rsp_freq_ff;
   logic [15:0] rsp_amp_ff, amp_in;
   logic [18:0] rsp_phase_ff;
   logic        rsp_running_ff;
   logic [2:0]  rsp_leds_ff;

   logic        run_ff, run_in;
   logic [11:0] target_ff, target_in;
   logic [9:0]  tick_ff, tick_in;
   logic [11:0] freq_ff, freq_in;
   logic [18:0] angle_ff, angle_in;

   logic c_free, b_free, a_move, b_move;

   logic [SUM_W-1:0]  adc_sum;
   logic [PROD_W-1:0] div_prod;
   logic [Q_W-1:0]    quot;

   logic [CMP_W-1:0] q_ext, max_ext;
   logic [7:0]       hz;
   logic [11:0]      hz_tenths;
   logic [2:0]       leds;
   logic [10:0]      tick_p1;
   logic             step_now;
   logic [12:0]      ramp_sum;
   logic [11:0]      ramp_diff, step_ext, freq_step;

   logic [35:0] amp_prod;
   logic [21:0] inc_prod;
   logic [19:0] angle_sum;

   assign c_free    = !rsp_valid_ff || rsp_ready;
   assign b_free    = !b_valid_ff || c_free;
   assign b_move    = b_valid_ff && c_free;
   assign a_move    = a_valid_ff && b_free;
   assign req_ready = !a_valid_ff || b_free;
   assign csr_ready = 1'b1;

   assign adc_sum  = SUM_W'(req_adc_target) + SUM_W'(vfrg_pkg::ADC_ROUND);
   assign div_prod = PROD_W'(adc_sum) * PROD_W'(vfrg_pkg::DIV82_RECIP);
   assign quot     = div_prod[vfrg_pkg::DIV82_SHIFT +: Q_W];

   always_comb begin
      run_in = run_ff;
      if (a_start_ff) begin
         run_in = 1'b1;
      end
      if (a_stop_ff) begin
         run_in = 1'b0;
      end

      q_ext   = CMP_W'(a_quot_ff);
      max_ext = CMP_W'(max_hz_ff);
      hz      = (q_ext > max_ext) ? max_hz_ff : q_ext[7:0];
      hz_tenths = 12'({hz, 3'b000}) + 12'({hz, 1'b0});

      priority if (run_in) begin
         target_in = hz_tenths;
      end else if (a_stop_ff) begin
         target_in = 12'd0;
      end else begin
         target_in = target_ff;
      end

      priority if (!run_in) begin
         leds = 3'd0;
      end else if (a_speed_ff <= lvl1_ff) begin
         leds = 3'd1;
      end else if (a_speed_ff <= lvl2_ff) begin
         leds = 3'd2;
      end else if (a_speed_ff <= lvl3_ff) begin
         leds = 3'd3;
      end else begin
         leds = 3'd4;
      end

      tick_p1   = {1'b0, tick_ff} + 11'd1;
      step_now  = !(tick_p1 < {1'b0, period_ff});
      step_ext  = 12'(step_ff);
      ramp_sum  = {1'b0, freq_ff} + 13'(step_ff);
      ramp_diff = freq_ff - target_in;

      priority if (!step_now) begin
         freq_step = freq_ff;
      end else if (freq_ff < target_in) begin
         freq_step = (ramp_sum > {1'b0, target_in}) ? target_in : ramp_sum[11:0];
      end else if (freq_ff > target_in) begin
         freq_step = (ramp_diff > step_ext) ? (freq_ff - step_ext) : target_in;
      end else begin
         freq_step = freq_ff;
      end

      freq_in = (freq_step > vfrg_pkg::FREQ_MAX) ? vfrg_pkg::FREQ_MAX : freq_step;
      tick_in = step_now ? 10'd0 : tick_p1[9:0];

      b_in.freq    = freq_in;
      b_in.running = run_in;
      b_in.leds    = leds;
   end

   always_comb begin
      amp_prod = 36'(b_ff.freq[8:0]) * 36'(vfrg_pkg::AMP_RECIP);
      amp_in   = (b_ff.freq >= vfrg_pkg::AMP_SAT_FREQ) ? vfrg_pkg::AMP_FULL
                                                      : amp_prod[vfrg_pkg::AMP_SHIFT +: 16];
      inc_prod  = 22'(b_ff.freq) * 22'(gain_ff);
      angle_sum = {1'b0, angle_ff} + 20'(inc_prod[21:8]);
      angle_in  = (angle_sum >= vfrg_pkg::ANGLE_WRAP) ? 19'd0 : angle_sum[18:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= vfrg_pkg::RST_RAMP_STEP;
         period_ff <= vfrg_pkg::RST_RAMP_PERIOD;
         max_hz_ff <= vfrg_pkg::RST_MAX_TARGET_HZ;
         gain_ff   <= vfrg_pkg::RST_ANGLE_GAIN;
         lvl1_ff   <= vfrg_pkg::RST_LED_LEVEL_ONE;
         lvl2_ff   <= vfrg_pkg::RST_LED_LEVEL_TWO;
         lvl3_ff   <= vfrg_pkg::RST_LED_LEVEL_THREE;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            vfrg_pkg::CSR_RAMP_STEP:       step_ff   <= csr_data[5:0];
            vfrg_pkg::CSR_RAMP_PERIOD:     period_ff <= csr_data[9:0];
            vfrg_pkg::CSR_MAX_TARGET_HZ:   max_hz_ff <= csr_data[7:0];
            vfrg_pkg::CSR_ANGLE_GAIN:      gain_ff   <= csr_data[9:0];
            vfrg_pkg::CSR_LED_LEVEL_ONE:   lvl1_ff   <= csr_data;
            vfrg_pkg::CSR_LED_LEVEL_TWO:   lvl2_ff   <= csr_data;
            vfrg_pkg::CSR_LED_LEVEL_THREE: lvl3_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         run_ff       <= 1'b0;
         target_ff    <= 12'd0;
         tick_ff      <= 10'd0;
         freq_ff      <= 12'd0;
         angle_ff     <= 19'd0;
      end else begin
         if (req_ready) begin
            a_valid_ff <= req_valid;
         end
         if (b_free) begin
            b_valid_ff <= a_valid_ff;
         end
         if (c_free) begin
            rsp_valid_ff <= b_valid_ff;
         end
         if (a_move) begin
            run_ff    <= run_in;
            target_ff <= target_in;
            tick_ff   <= tick_in;
            freq_ff   <= freq_in;
         end
         if (b_move) begin
            angle_ff <= angle_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         a_quot_ff  <= quot;
         a_start_ff <= req_start_button;
         a_stop_ff  <= req_stop_button;
         a_speed_ff <= req_speed_el;
      end
      if (a_move) begin
         b_ff <= b_in;
      end
      if (b_move) begin
         rsp_freq_ff    <= b_ff.freq;
         rsp_amp_ff     <= amp_in;
         rsp_phase_ff   <= angle_ff;
         rsp_running_ff <= b_ff.running;
         rsp_leds_ff    <= b_ff.leds;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_freq_tenths = rsp_freq_ff;
   assign rsp_amplitude   = rsp_amp_ff;
   assign rsp_phase_angle = rsp_phase_ff;
   assign rsp_running     = rsp_running_ff;
   assign rsp_led_count   = rsp_leds_ff;

   `VFRG_ASSERT_IMPL(a_freq_bound, 1'b1, freq_ff <= vfrg_pkg::FREQ_MAX)
   `VFRG_ASSERT_IMPL(a_angle_bound, 1'b1, {1'b0, angle_ff} < vfrg_pkg::ANGLE_WRAP)
   `VFRG_ASSERT_IMPL(a_leds_off, rsp_valid_ff && !rsp_running_ff, rsp_leds_ff == 3'd0)
   `VFRG_ASSERT_NEXT(a_result_follows, b_valid_ff && c_free, rsp_valid_ff)

endmodule

FILE: dv/tb_vf_frequency_ramp_generator_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the V/f frequency ramp generator: ramp, amplitude,
// phase angle and speed bar predicted per control tick and compared on every result.
// Depends on vfrg_pkg and vf_frequency_ramp_generator_top.

typedef struct {
   logic [11:0] freq;
   logic [15:0] amp;
   logic [18:0] phase;
   logic        running;
   logic [2:0]  leds;
} tick_output_type;

class ramp_scoreboard;
   bit [5:0]         step_size;
   bit [9:0]         step_period;
   bit [7:0]         cap_hz;
   bit [9:0]         gain;
   bit signed [15:0] level_one;
   bit signed [15:0] level_two;
   bit signed [15:0] level_three;
   bit               run_on;
   bit [11:0]        target;
   bit [9:0]         ticks;
   bit [11:0]        freq;
   bit [18:0]        angle;
   tick_output_type  expected_outputs[$];
   int               errors;

   function new();
      step_size = vfrg_pkg::RST_RAMP_STEP;
      step_period = vfrg_pkg::RST_RAMP_PERIOD;
      cap_hz = vfrg_pkg::RST_MAX_TARGET_HZ;
      gain = vfrg_pkg::RST_ANGLE_GAIN;
      level_one = vfrg_pkg::RST_LED_LEVEL_ONE;
      level_two = vfrg_pkg::RST_LED_LEVEL_TWO;
      level_three = vfrg_pkg::RST_LED_LEVEL_THREE;
      run_on = 1'b0;
      target = '0;
      ticks = '0;
      freq = '0;
      angle = '0;
      errors = 0;
   endfunction

   function void write_reg(vfrg_pkg::csr_index_type idx, logic [15:0] data);
      case (idx)
         vfrg_pkg::CSR_RAMP_STEP:       step_size = data[5:0];
         vfrg_pkg::CSR_RAMP_PERIOD:     step_period = data[9:0];
         vfrg_pkg::CSR_MAX_TARGET_HZ:   cap_hz = data[7:0];
         vfrg_pkg::CSR_ANGLE_GAIN:      gain = data[9:0];
         vfrg_pkg::CSR_LED_LEVEL_ONE:   level_one = data;
         vfrg_pkg::CSR_LED_LEVEL_TWO:   level_two = data;
         vfrg_pkg::CSR_LED_LEVEL_THREE: level_three = data;
         default: ;
      endcase
   endfunction

   function int pending();
      return expected_outputs.size();
   endfunction

   function void note_tick(logic [11:0] adc, logic start, logic stop,
                           logic signed [15:0] speed);
      int hz;
      int f;
      int tgt;
      int amp;
      int next_angle;
      tick_output_type o;
      if (start) run_on = 1'b1;
      if (stop) begin
         target = '0;
         run_on = 1'b0;
      end
      if (run_on) begin
         hz = (int'(adc) + 42) / 82;
         if (hz > int'(cap_hz)) hz = int'(cap_hz);
         target = 12'(hz * 10);
      end
      if (!run_on) o.leds = 3'd0;
      else if (speed <= level_one) o.leds = 3'd1;
      else if (speed <= level_two) o.leds = 3'd2;
      else if (speed <= level_three) o.leds = 3'd3;
      else o.leds = 3'd4;
      if (int'(ticks) + 1 < int'(step_period)) begin
         ticks = ticks + 10'd1;
      end else begin
         f = int'(freq);
         tgt = int'(target);
         if (f < tgt) begin
            f = f + int'(step_size);
            if (f > tgt) f = tgt;
         end else if (f > tgt) begin
            if (f - tgt > int'(step_size)) f = f - int'(step_size);
            else f = tgt;
         end
         freq = 12'(f);
         ticks = '0;
      end
      if (freq > vfrg_pkg::FREQ_MAX) freq = vfrg_pkg::FREQ_MAX;
      amp = int'(freq) * 32768 / 500;
      if (amp > 32768) amp = 32768;
      next_angle = int'(angle) + ((int'(freq) * int'(gain)) >> 8);
      if (next_angle >= 400000) next_angle = 0;
      o.freq = freq;
      o.amp = 16'(amp);
      o.phase = angle;
      o.running = run_on;
      angle = 19'(next_angle);
      expected_outputs.push_back(o);
   endfunction

   function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   function void check_output(logic [11:0] f, logic [15:0] amp, logic [18:0] phase,
                              logic running, logic [2:0] leds);
      tick_output_type e;
      if (expected_outputs.size() == 0) begin
         $display("%0t: result item with no tick outstanding, freq_tenths %0d", $time, f);
         errors++;
         return;
      end
      e = expected_outputs.pop_front();
      compare_field("freq_tenths", e.freq, f);
      compare_field("amplitude", e.amp, amp);
      compare_field("phase_angle", e.phase, phase);
      compare_field("running", e.running, running);
      compare_field("led_count", e.leds, leds);
   endfunction
endclass

module tb_vf_frequency_ramp_generator_top;
   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [11:0]             req_adc_target;
   logic                    req_start_button;
   logic                    req_stop_button;
   logic signed [15:0]      req_speed_el;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [11:0]             rsp_freq_tenths;
   logic [15:0]             rsp_amplitude;
   logic [18:0]             rsp_phase_angle;
   logic                    rsp_running;
   logic [2:0]              rsp_led_count;
   logic                    csr_valid;
   logic                    csr_ready;
   vfrg_pkg::csr_index_type csr_index;
   logic [15:0]             csr_data;

   bit             calm = 0;
   ramp_scoreboard sb;

   vf_frequency_ramp_generator_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_adc_target(req_adc_target),
      .req_start_button(req_start_button),
      .req_stop_button(req_stop_button),
      .req_speed_el(req_speed_el),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_freq_tenths(rsp_freq_tenths),
      .rsp_amplitude(rsp_amplitude),
      .rsp_phase_angle(rsp_phase_angle),
      .rsp_running(rsp_running),
      .rsp_led_count(rsp_led_count),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 24);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_valid && req_ready)
            sb.note_tick(req_adc_target, req_start_button, req_stop_button, req_speed_el);
         if (rsp_valid && rsp_ready)
            sb.check_output(rsp_freq_tenths, rsp_amplitude, rsp_phase_angle,
                            rsp_running, rsp_led_count);
      end
   end

   task automatic send_tick(input logic [11:0] adc, input logic start, input logic stop,
                            input logic signed [15:0] speed);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_adc_target <= adc;
      req_start_button <= start;
      req_stop_button <= stop;
      req_speed_el <= speed;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input vfrg_pkg::csr_index_type idx, input logic [15:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic load_settings(input int step, input int period, input int cap, input int g,
                                input logic [15:0] l1, input logic [15:0] l2,
                                input logic [15:0] l3);
      write_csr(vfrg_pkg::CSR_RAMP_STEP, 16'(step));
      write_csr(vfrg_pkg::CSR_RAMP_PERIOD, 16'(period));
      write_csr(vfrg_pkg::CSR_MAX_TARGET_HZ, 16'(cap));
      write_csr(vfrg_pkg::CSR_ANGLE_GAIN, 16'(g));
      write_csr(vfrg_pkg::CSR_LED_LEVEL_ONE, l1);
      write_csr(vfrg_pkg::CSR_LED_LEVEL_TWO, l2);
      write_csr(vfrg_pkg::CSR_LED_LEVEL_THREE, l3);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic signed [15:0] speeds [5];
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic signed [15:0] c;
      logic signed [15:0] t;
      logic [11:0]        adc_level;
      logic               start;
      logic               stop;
      bit                 seq_on;
      int                 ph;
      int                 i;
      speeds = '{-16'sd32767, 16'sd0, 16'sd1, 16'sd32766, 16'sd32767};
      sb = new();
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_adc_target = '0;
      req_start_button = 1'b0;
      req_stop_button = 1'b0;
      req_speed_el = '0;
      csr_valid = 1'b0;
      csr_index = vfrg_pkg::CSR_RAMP_STEP;
      csr_data = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Default settings: speed bar boundaries around the first and third reset levels.
      send_tick(12'd4095, 1'b1, 1'b0, 16'sd10);
      send_tick(12'd4095, 1'b0, 1'b0, 16'sd11);
      send_tick(12'd4095, 1'b0, 1'b0, 16'sd41);
      send_tick(12'd4095, 1'b0, 1'b0, 16'sd40);
      drain();

      // Step of 50 on every tick with a zero period, a cap above 250 Hz and extreme levels.
      load_settings(50, 0, 255, 1023, 16'h8000, 16'h0000, 16'h7FFE);
      send_tick(12'd4095, 1'b1, 1'b1, 16'sd0);
      send_tick(12'd4095, 1'b1, 1'b0, -16'sd32768);
      for (i = 0; i < 10; i++) send_tick(12'd4095, 1'b0, 1'b0, speeds[i % 5]);
      send_tick(12'd0, 1'b0, 1'b0, 16'sd0);
      send_tick(12'd40, 1'b0, 1'b0, 16'sd0);
      send_tick(12'd4095, 1'b0, 1'b1, 16'sd0);
      send_tick(12'd4095, 1'b0, 1'b1, 16'sd0);
      send_tick(12'd0, 1'b1, 1'b0, 16'sd0);

      seq_on = 1;
      adc_level = 12'd4095;
      for (ph = 0; ph < 7; ph++) begin
         drain();
         a = 16'($urandom_range(0, 65535));
         b = 16'($urandom_range(0, 65535));
         c = 16'($urandom_range(0, 65535));
         if (a > b) begin t = a; a = b; b = t; end
         if (b > c) begin t = b; b = c; c = t; end
         if (a > b) begin t = a; a = b; b = t; end
         case (ph)
            0: load_settings(50, 1, 250, 1023, a, b, c);
            1: load_settings(0, 1023, 0, 0, 16'h8000, 16'h8000, 16'h8000);
            2: load_settings(1, 0, 255, 256, 16'h7FFF, 16'h7FFF, 16'h7FFF);
            default: load_settings($urandom_range(0, 50), $urandom_range(1, 6),
                                   ($urandom_range(3) == 0) ? 250 : $urandom_range(0, 60),
                                   $urandom_range(0, 1023), a, b, c);
         endcase
         calm = (ph == 4);
         for (i = 0; i < 75; i++) begin
            start = (!seq_on && $urandom_range(9) < 3) || $urandom_range(99) < 3;
            stop = (seq_on && $urandom_range(99) < 4) || $urandom_range(99) < 2;
            if (stop) seq_on = 0;
            else if (start) seq_on = 1;
            if ($urandom_range(99) < 10) adc_level = 12'($urandom_range(0, 4095));
            send_tick(($urandom_range(99) < 80) ? adc_level : 12'($urandom_range(0, 4095)),
                      start, stop, 16'($urandom_range(0, 65535)));
         end
      end
      calm = 0;
      drain();

      if (sb.errors == 0) begin
         $display("tb_vf_frequency_ramp_generator_top passed");
      end else begin
         $display("tb_vf_frequency_ramp_generator_top failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_vf_frequency_ramp_generator_top failed");
      $finish;
   end
endmodule

FILE: vf_frequency_ramp_generator_top.f
+incdir+rtl
rtl/vfrg_pkg.sv
rtl/vf_frequency_ramp_generator_top.sv
dv/tb_vf_frequency_ramp_generator_top.sv
